// File: rtl/core/vcf_pkg.sv
// ----------------------------------------------------------------------------
// vcf_pkg
// Types and codes shared by the vending controller modules.
// ----------------------------------------------------------------------------
`default_nettype none

package vcf_pkg;

  localparam int NUM_PRICES = 4;

  typedef enum logic [1:0] {
    MODE_NOCOIN  = 2'd0,
    MODE_HASCOIN = 2'd1,
    MODE_DISP    = 2'd2,
    MODE_SOLDOUT = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CMD_INSERT   = 3'd0,
    CMD_SELECT   = 3'd1,
    CMD_DISPENSE = 3'd2,
    CMD_RETURN   = 3'd3,
    CMD_REFILL   = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    ST_TAKEN      = 4'd0,
    ST_BOUNCED    = 4'd1,
    ST_NEEDCOIN   = 4'd2,
    ST_BADIDX     = 4'd3,
    ST_EMPTY      = 4'd4,
    ST_SHORT      = 4'd5,
    ST_VEND       = 4'd6,
    ST_DISPENSED  = 4'd7,
    ST_REFUNDED   = 4'd8,
    ST_REFILLED   = 4'd9,
    ST_REFUSED    = 4'd10,
    ST_NOTALLOWED = 4'd11
  } status_t;

  typedef enum logic [2:0] {
    REG_PRODUCTS = 3'd0,
    REG_PRICE0   = 3'd1,
    REG_PRICE1   = 3'd2,
    REG_PRICE2   = 3'd3,
    REG_PRICE3   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [9:0]  coin_value;
    logic [2:0]  product_index;
    logic [7:0]  refill_count;
  } cmd_item_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] credit;
    logic [1:0]  chosen_slot;
  } ctrl_state_t;

  typedef struct packed {
    status_t     status;
    mode_t       machine_state;
    logic [15:0] balance;
    logic [15:0] change_amount;
    logic [15:0] returned_amount;
    logic [15:0] shortfall;
    logic [1:0]  dispensed_slot;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/vending_controller_fsm.sv
// ----------------------------------------------------------------------------
// vending_controller_fsm
// Vending controller: coin credit, product selection, dispense and refill.
//
//   channel  dir  tdata                               tuser
//   in_      in   coin_value, product_index,          cmd
//                 refill_count
//   out_     out  machine_state, balance, change,     status
//                 returned, shortfall, dispensed_slot
//   cfg_     in   index selects register, data value  -
//
// one command per cycle while the output is not stalled; the command passes
// through the input register to the decode, which updates the state registers
// as the result is written to the output register
// reset clears credit and stock, so the machine starts sold out
// a stalled output holds the result; input accepts while its register is empty or the stage advances
// ----------------------------------------------------------------------------
`default_nettype none

module vending_controller_fsm #(
  parameter int MAX_SLOTS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // coin_value, product_index, refill_count, pad
  input  logic [2:0]  in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // machine_state, balance, change_amount,
                                  // returned_amount, shortfall, dispensed_slot, pad
  output logic [3:0]  out_tuser,  // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import vcf_pkg::*;

  localparam int SLOTS = (MAX_SLOTS < 4) ? MAX_SLOTS : 4;

  cmd_item_t   item_r;
  logic        in_v_r;
  logic        out_v_r;
  result_t     res_r;
  result_t     res_nxt;
  ctrl_state_t state_r;
  ctrl_state_t state_nxt;
  logic [7:0]  stock_r   [SLOTS];
  logic [7:0]  stock_nxt [SLOTS];
  logic [2:0]  piu_r;
  logic [15:0] price_r   [NUM_PRICES];
  logic        advance;

  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;
  assign cfg_ready = 1'b1;

  vcf_step #(.SLOTS(SLOTS)) u_step (
    .item            (item_r),
    .state           (state_r),
    .stock           (stock_r),
    .products_in_use (piu_r),
    .price           (price_r),
    .state_nxt       (state_nxt),
    .stock_nxt       (stock_nxt),
    .result          (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      state_r <= '{mode: MODE_SOLDOUT, credit: 16'd0, chosen_slot: 2'd0};
      for (int i = 0; i < SLOTS; i++) stock_r[i] <= 8'd0;
    end else begin
      if (in_tvalid && in_tready) begin
        in_v_r <= 1'b1;
      end else if (advance) begin
        in_v_r <= 1'b0;
      end
      if (advance) begin
        out_v_r <= 1'b1;
        state_r <= state_nxt;
        for (int i = 0; i < SLOTS; i++) stock_r[i] <= stock_nxt[i];
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.cmd           <= cmd_t'(in_tuser);
      item_r.coin_value    <= in_tdata[9:0];
      item_r.product_index <= in_tdata[12:10];
      item_r.refill_count  <= in_tdata[20:13];
    end
    if (advance) res_r <= res_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      piu_r <= 3'd4;
      for (int i = 0; i < NUM_PRICES; i++) price_r[i] <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PRODUCTS: piu_r      <= cfg_data[2:0];
        REG_PRICE0:   price_r[0] <= cfg_data;
        REG_PRICE1:   price_r[1] <= cfg_data;
        REG_PRICE2:   price_r[2] <= cfg_data;
        REG_PRICE3:   price_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = res_r.status;
  assign out_tdata  = {4'b0, res_r.dispensed_slot, res_r.shortfall,
                       res_r.returned_amount, res_r.change_amount,
                       res_r.balance, res_r.machine_state};

  a_vend_clears_balance: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.status == ST_VEND |-> res_r.balance == 16'd0 &&
      res_r.machine_state == MODE_DISP)
    else $error("vend result without cleared balance");

  a_disp_no_credit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.mode == MODE_DISP |-> state_r.credit == 16'd0)
    else $error("credit held while dispensing");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_v_r && res_r.machine_state == state_r.mode)
    else $error("result register out of step with state");

  a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !advance |=> in_v_r && $stable(item_r))
    else $error("held command lost during stall");

  a_dispensed_leaves_disp: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.status == ST_DISPENSED |->
      res_r.machine_state == MODE_NOCOIN || res_r.machine_state == MODE_SOLDOUT)
    else $error("dispense left machine in wrong state");

endmodule

`default_nettype wire

// File: rtl/core/vcf_step.sv
// ----------------------------------------------------------------------------
// vcf_step
// Combinational command decode: next controller state, stock and result.
// ----------------------------------------------------------------------------
`default_nettype none

module vcf_step #(
  parameter int SLOTS = 4
) (
  input  vcf_pkg::cmd_item_t   item,
  input  vcf_pkg::ctrl_state_t state,
  input  logic [7:0]           stock [SLOTS],
  input  logic [2:0]           products_in_use,
  input  logic [15:0]          price [vcf_pkg::NUM_PRICES],
  output vcf_pkg::ctrl_state_t state_nxt,
  output logic [7:0]           stock_nxt [SLOTS],
  output vcf_pkg::result_t     result
);
  import vcf_pkg::*;

  localparam logic [3:0] SLOTS_W = 4'(SLOTS);

  logic        valid_idx;
  logic        refill_ok;
  logic        all_empty;
  logic [15:0] sel_price;
  logic [7:0]  sel_stock;
  logic [16:0] credit_sum;
  logic [15:0] credit_sat;
  logic [8:0]  refill_sum;

  assign valid_idx = ({1'b0, item.product_index} < {1'b0, products_in_use}) &&
                     ({1'b0, item.product_index} < SLOTS_W);
  assign refill_ok = ((state.mode == MODE_NOCOIN) || (state.mode == MODE_SOLDOUT)) &&
                     valid_idx;
  assign sel_price  = price[item.product_index[1:0]];
  assign credit_sum = {1'b0, state.credit} + {7'b0, item.coin_value};
  assign credit_sat = credit_sum[16] ? 16'hFFFF : credit_sum[15:0];

  always_comb begin
    sel_stock = 8'd0;
    for (int i = 0; i < SLOTS; i++) begin
      if (2'(i) == item.product_index[1:0]) sel_stock = stock[i];
    end
  end

  assign refill_sum = {1'b0, sel_stock} + {1'b0, item.refill_count};

  // stock update
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      stock_nxt[i] = stock[i];
      if (item.cmd == CMD_REFILL && refill_ok && item.product_index[1:0] == 2'(i)) begin
        stock_nxt[i] = refill_sum[8] ? 8'hFF : refill_sum[7:0];
      end
      if (item.cmd == CMD_DISPENSE && state.mode == MODE_DISP &&
          state.chosen_slot == 2'(i) && stock[i] != 8'd0) begin
        stock_nxt[i] = stock[i] - 8'd1;
      end
    end
  end

  always_comb begin
    all_empty = 1'b1;
    for (int i = 0; i < SLOTS; i++) begin
      if (3'(i) < products_in_use && stock_nxt[i] != 8'd0) all_empty = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state;
    unique case (item.cmd)
      CMD_INSERT: begin
        if (state.mode == MODE_NOCOIN) begin
          state_nxt.credit = {6'b0, item.coin_value};
          state_nxt.mode   = MODE_HASCOIN;
        end else if (state.mode == MODE_HASCOIN) begin
          state_nxt.credit = credit_sat;
        end
      end
      CMD_SELECT: begin
        if (state.mode == MODE_HASCOIN && valid_idx) begin
          state_nxt.chosen_slot = item.product_index[1:0];
          if (sel_stock != 8'd0 && state.credit >= sel_price) begin
            state_nxt.credit = 16'd0;
            state_nxt.mode   = MODE_DISP;
          end
        end
      end
      CMD_DISPENSE: begin
        if (state.mode == MODE_DISP) begin
          state_nxt.mode = all_empty ? MODE_SOLDOUT : MODE_NOCOIN;
        end
      end
      CMD_RETURN: begin
        if (state.mode == MODE_HASCOIN) begin
          state_nxt.credit = 16'd0;
          state_nxt.mode   = MODE_NOCOIN;
        end
      end
      CMD_REFILL: begin
        if (refill_ok) state_nxt.mode = MODE_NOCOIN;
      end
      default: ;
    endcase
  end

  // result
  always_comb begin
    result                 = '0;
    result.status          = ST_NOTALLOWED;
    result.machine_state   = state_nxt.mode;
    result.balance         = state_nxt.credit;
    unique case (item.cmd)
      CMD_INSERT: begin
        if (state.mode == MODE_NOCOIN || state.mode == MODE_HASCOIN) begin
          result.status = ST_TAKEN;
        end else begin
          result.status          = ST_BOUNCED;
          result.returned_amount = {6'b0, item.coin_value};
        end
      end
      CMD_SELECT: begin
        if (state.mode == MODE_NOCOIN) begin
          result.status = ST_NEEDCOIN;
        end else if (state.mode == MODE_HASCOIN) begin
          if (!valid_idx) begin
            result.status = ST_BADIDX;
          end else if (sel_stock == 8'd0) begin
            result.status = ST_EMPTY;
          end else if (state.credit >= sel_price) begin
            result.status        = ST_VEND;
            result.change_amount = state.credit - sel_price;
          end else begin
            result.status    = ST_SHORT;
            result.shortfall = sel_price - state.credit;
          end
        end
      end
      CMD_DISPENSE: begin
        if (state.mode == MODE_NOCOIN) begin
          result.status = ST_NEEDCOIN;
        end else if (state.mode == MODE_DISP) begin
          result.status         = ST_DISPENSED;
          result.dispensed_slot = state.chosen_slot;
        end
      end
      CMD_RETURN: begin
        if (state.mode == MODE_HASCOIN) begin
          result.status          = ST_REFUNDED;
          result.returned_amount = state.credit;
        end
      end
      CMD_REFILL: begin
        result.status = refill_ok ? ST_REFILLED : ST_REFUSED;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
